// ----- rtl/hact_pkg.sv -----
// hot address count table: shared types, constants and state codes
// no dependencies
package hact_pkg;

  localparam int unsigned AddrWidth = 24;
  localparam int unsigned OpWidth   = 8;
  localparam int unsigned LenWidth  = 2;
  localparam int unsigned OperWidth = 24;
  localparam int unsigned OutCntWidth = 32;
  localparam int unsigned OccWidth  = 11;
  localparam int unsigned RegAddrWidth = 3;

  localparam logic [RegAddrWidth-1:0] RegRecordEnable = 3'd0;
  localparam logic [RegAddrWidth-1:0] RegMaxEntries   = 3'd4;

  // scan modes: search hit, min scan, free scan
  localparam logic [2:0] ModeSearch = 3'd0;
  localparam logic [2:0] ModeMin    = 3'd1;
  localparam logic [2:0] ModeFree   = 3'd2;

  typedef struct packed {
    logic [AddrWidth-1:0] address;
    logic [OpWidth-1:0]   opcode;
    logic [LenWidth-1:0]  operand_len;
    logic [OperWidth-1:0] operand_bytes;
  } hact_in_t;

  typedef struct packed {
    logic                   accepted;
    logic                   was_new;
    logic [OutCntWidth-1:0] exec_count;
    logic [OccWidth-1:0]    evicted;
    logic [OccWidth-1:0]    entries_used;
  } hact_out_t;

  typedef enum logic [3:0] {
    StIdle,
    StSearch,
    StSearchWait,
    StHit,
    StTrimCheck,
    StMinScan,
    StMinWait,
    StEvict,
    StFreeScan,
    StInsert,
    StDone
  } hact_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic scan_start;
    logic scan_step;
    logic do_hit;
    logic do_evict;
    logic do_insert;
    logic do_idle_result;
  } hact_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clearing;
    logic scan_last;
    logic found;
    logic min_found;
    logic free_found;
    logic need_trim;
    logic above_target;
  } hact_sts_t;

endpackage

// ----- rtl/hact_datapath.sv -----
// hot address count table: entry stores, scan pointer, min tracker, result register
// depends on hact_pkg
module hact_datapath #(
  parameter int unsigned TableDepth = 1024,
  parameter int unsigned CountWidth = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hact_pkg::hact_in_t   item_i,
  input  logic [10:0]          max_entries_i,
  input  hact_pkg::hact_cmd_t  cmd_i,
  input  logic [2:0]           mode_i,
  output hact_pkg::hact_sts_t  sts_o,
  output hact_pkg::hact_out_t  result_o
);
  import hact_pkg::*;

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned OccW = $clog2(TableDepth + 1);
  localparam int unsigned ProdW = OccW + 18;
  localparam logic [CountWidth-1:0] CntMax = '1;
  // ceil(2^18 / 5), exact for the fifth of any 13-bit value
  localparam logic [ProdW-1:0] RecipFifth = ProdW'(52429);

  logic                  valid_mem [TableDepth];
  logic [AddrWidth-1:0]  addr_mem [TableDepth];
  logic [CountWidth-1:0] cnt_mem  [TableDepth];

  hact_in_t            item_q;
  logic [IdxW-1:0]     ptr_q, rd_idx_q;
  logic                rd_vld_q, last_q;
  logic                rd_valid_q;
  logic [AddrWidth-1:0]  rd_addr_q;
  logic [CountWidth-1:0] rd_cnt_q;
  logic [IdxW-1:0]     slot_q;
  logic                found_q, min_found_q, free_found_q;
  logic [CountWidth-1:0] min_cnt_q;
  logic [AddrWidth-1:0]  min_addr_q;
  logic [OccW-1:0]     used_q;
  logic [OccW-1:0]     evicted_q;
  hact_out_t           result_q;
  logic                clr_q;
  logic [IdxW-1:0]     clr_ptr_q;

  // effective max and trim target
  logic [OccW-1:0]  eff_max;
  logic [ProdW-1:0] prod;
  logic [OccW-1:0]  target;
  always_comb begin
    if (max_entries_i == '0) eff_max = OccW'(1);
    else if ({21'd0, max_entries_i} > 32'(TableDepth)) eff_max = OccW'(TableDepth);
    else eff_max = OccW'(max_entries_i);
    prod   = ProdW'({eff_max, 2'b00}) * RecipFifth;
    target = prod[ProdW-1:18];
  end

  assign sts_o.clearing     = clr_q;
  assign sts_o.scan_last    = last_q;
  assign sts_o.found        = found_q;
  assign sts_o.min_found    = min_found_q;
  assign sts_o.free_found   = free_found_q;
  assign sts_o.need_trim    = (used_q >= eff_max);
  assign sts_o.above_target = (used_q > target);

  // memory read port, registered
  always_ff @(posedge clk_i) begin
    rd_valid_q <= valid_mem[ptr_q];
    rd_addr_q  <= addr_mem[ptr_q];
    rd_cnt_q   <= cnt_mem[ptr_q];
    rd_idx_q   <= ptr_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= item_i;
    // clearing pass after reset, one entry a cycle
    if (clr_q) valid_mem[clr_ptr_q] <= 1'b0;
    if (cmd_i.do_evict) valid_mem[slot_q] <= 1'b0;
    if (cmd_i.do_hit && rd_cnt_q != CntMax) cnt_mem[slot_q] <= rd_cnt_q + 1'b1;
    if (cmd_i.do_insert) begin
      valid_mem[slot_q] <= 1'b1;
      addr_mem[slot_q]  <= item_q.address;
      cnt_mem[slot_q]   <= CountWidth'(1);
    end
  end

  logic better;
  always_comb begin
    better = !min_found_q || rd_cnt_q < min_cnt_q ||
             (rd_cnt_q == min_cnt_q && rd_addr_q < min_addr_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q        <= 1'b1;
      clr_ptr_q    <= '0;
      ptr_q        <= '0;
      rd_vld_q     <= 1'b0;
      last_q       <= 1'b0;
      slot_q       <= '0;
      found_q      <= 1'b0;
      min_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      min_cnt_q    <= '0;
      min_addr_q   <= '0;
      used_q       <= '0;
      evicted_q    <= '0;
      result_q     <= '0;
    end else begin
      if (clr_q) begin
        clr_ptr_q <= clr_ptr_q + 1'b1;
        if (clr_ptr_q == IdxW'(TableDepth - 1)) clr_q <= 1'b0;
      end
      if (cmd_i.load_item) evicted_q <= '0;
      if (cmd_i.scan_start) begin
        ptr_q        <= '0;
        rd_vld_q     <= 1'b0;
        last_q       <= 1'b0;
        found_q      <= 1'b0;
        min_found_q  <= 1'b0;
        free_found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        rd_vld_q <= 1'b1;
        if (ptr_q != IdxW'(TableDepth - 1)) ptr_q <= ptr_q + 1'b1;
        if (rd_vld_q) begin
          if (rd_idx_q == IdxW'(TableDepth - 1)) last_q <= 1'b1;
          unique case (mode_i)
            ModeSearch: if (!found_q && rd_valid_q &&
                            rd_addr_q == item_q.address) begin
              found_q <= 1'b1;
              slot_q  <= rd_idx_q;
            end
            ModeMin: if (rd_valid_q && better) begin
              min_found_q <= 1'b1;
              min_cnt_q   <= rd_cnt_q;
              min_addr_q  <= rd_addr_q;
              slot_q      <= rd_idx_q;
            end
            ModeFree: if (!free_found_q && !rd_valid_q) begin
              free_found_q <= 1'b1;
              slot_q       <= rd_idx_q;
            end
            default: ;
          endcase
        end
      end
      if (cmd_i.do_hit) begin
        // rereads the hit slot's count via the port
        result_q.accepted   <= 1'b1;
        result_q.was_new    <= 1'b0;
        result_q.exec_count <= OutCntWidth'(
          (rd_cnt_q != CntMax) ? rd_cnt_q + 1'b1 : rd_cnt_q);
        result_q.evicted    <= '0;
        result_q.entries_used <= OccWidth'(used_q);
      end
      if (cmd_i.do_evict) begin
        used_q    <= used_q - 1'b1;
        evicted_q <= evicted_q + 1'b1;
      end
      if (cmd_i.do_insert) begin
        used_q <= used_q + 1'b1;
        result_q.accepted     <= 1'b1;
        result_q.was_new      <= 1'b1;
        result_q.exec_count   <= OutCntWidth'(1);
        result_q.evicted      <= OccWidth'(evicted_q);
        result_q.entries_used <= OccWidth'(used_q + 1'b1);
      end
      if (cmd_i.do_idle_result) begin
        result_q <= '{accepted: 1'b0, was_new: 1'b0, exec_count: '0, evicted: '0,
                      entries_used: OccWidth'(used_q)};
      end
      // point the read port at the hit slot
      if (cmd_i.load_item == 1'b0 && !cmd_i.scan_step && !cmd_i.scan_start &&
          found_q) ptr_q <= slot_q;
    end
  end

  assign result_o = result_q;
endmodule

// ----- rtl/hact_ctrl.sv -----
// hot address count table: sequencing state machine
// depends on hact_pkg
module hact_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic                record_enable_i,
  input  hact_pkg::hact_sts_t sts_i,
  output hact_pkg::hact_cmd_t cmd_o,
  output logic [2:0]          mode_o
);
  import hact_pkg::*;

  hact_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    mode_o      = ModeSearch;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        in_ready_o = !sts_i.clearing && (!out_valid_q || out_ready_i);
        if (in_valid_i && in_ready_o) begin
          cmd_o.load_item = 1'b1;
          if (record_enable_i) begin
            cmd_o.scan_start = 1'b1;
            state_d = StSearch;
          end else begin
            cmd_o.do_idle_result = 1'b1;
            out_valid_d = 1'b1;
          end
        end
      end
      StSearch: begin
        mode_o = ModeSearch;
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          cmd_o.scan_step = 1'b0;
          state_d = sts_i.found ? StSearchWait : StTrimCheck;
        end
      end
      StSearchWait: state_d = StHit; // read port settles on hit slot
      StHit: begin
        cmd_o.do_hit = 1'b1;
        out_valid_d  = 1'b1;
        state_d      = StIdle;
      end
      StTrimCheck: begin
        if (sts_i.need_trim && sts_i.above_target) begin
          cmd_o.scan_start = 1'b1;
          state_d = StMinScan;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = StFreeScan;
        end
      end
      StMinScan: begin
        mode_o = ModeMin;
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          cmd_o.scan_step = 1'b0;
          state_d = StEvict;
        end
      end
      StEvict: begin
        cmd_o.do_evict = sts_i.min_found;
        state_d = StMinWait;
      end
      StMinWait: begin
        cmd_o.scan_start = 1'b1;
        state_d = sts_i.above_target ? StMinScan : StFreeScan;
      end
      StFreeScan: begin
        mode_o = ModeFree;
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          cmd_o.scan_step = 1'b0;
          state_d = StInsert;
        end
      end
      StInsert: begin
        cmd_o.do_insert = 1'b1;
        state_d = StDone;
      end
      StDone: begin
        out_valid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_o = out_valid_q;
endmodule

// ----- rtl/hot_address_count_table.sv -----
// hot address count table: top level with register port
// depends on hact_pkg, hact_ctrl, hact_datapath
//
// usage: each input word reports one executed instruction (address, opcode,
// operand bytes). with recording on, a hit bumps that address's saturating
// count; a miss inserts it with count 1, first trimming the lowest-count
// entries (ties: lower address) down to 4/5 of max_entries when full.
// one result word per input word, one word in flight at a time.
// from the accepting edge to result valid, a hit takes a full lookup walk,
// a reread of the hit slot and an update; a miss takes the lookup walk, a
// trim check, a free-slot walk, the insert and the result; each evicted
// entry adds a min walk, the evict and a recheck. the walks go through the
// single read port of the entry memory. with recording off the result is
// valid in the cycle right after the accepting edge.
// reset clears occupancy and registers (record on, max 1024), then a
// clearing pass zeroes the valid bits of all TABLE_DEPTH entries; no word
// is taken until it ends.
// a stalled receiver holds the result register; a new word is taken once
// the result register is free or being taken.
module hot_address_count_table #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hact_pkg::hact_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hact_pkg::hact_out_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import hact_pkg::*;

  logic        record_enable_q;
  logic [10:0] max_entries_q;
  hact_cmd_t   cmd;
  hact_sts_t   sts;
  logic [2:0]  mode;

  assign pready = 1'b1;

  // register writes on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_enable_q <= 1'b1;
      max_entries_q   <= 11'd1024;
    end else if (psel && penable && pwrite) begin
      if (paddr == RegRecordEnable) record_enable_q <= pwdata[0];
      else if (paddr == RegMaxEntries) max_entries_q <= pwdata[10:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == RegRecordEnable) prdata = {31'd0, record_enable_q};
    else if (paddr == RegMaxEntries) prdata = {21'd0, max_entries_q};
  end

  hact_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .record_enable_i(record_enable_q), .sts_i(sts), .cmd_o(cmd), .mode_o(mode)
  );

  hact_datapath #(.TableDepth(TABLE_DEPTH), .CountWidth(COUNT_WIDTH)) u_dp (
    .clk_i, .rst_ni, .item_i(in_data_i), .max_entries_i(max_entries_q),
    .cmd_i(cmd), .mode_i(mode), .sts_o(sts), .result_o(out_data_o)
  );
endmodule

// ----- test/hot_address_count_table_tb.sv -----
// testbench for hot_address_count_table: directed and random instruction words,
// a self-contained table predictor, and a register port driver for config phases
// depends on hact_pkg and the hot_address_count_table rtl
module hot_address_count_table_tb;
  import hact_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 1024;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  hact_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  hact_out_t out_data_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  hot_address_count_table u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #(64'd400_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  // table predictor state
  logic        tbl_valid [Depth];
  logic [23:0] tbl_addr  [Depth];
  logic [31:0] tbl_count [Depth];
  int unsigned tbl_used = 0;
  logic        rec_on = 1'b1;
  logic [10:0] max_reg = 11'd1024;

  hact_in_t  word_q[$];     // instruction words waiting to be driven
  hact_out_t result_q[$];   // predicted results in order
  int errors = 0, n_hits = 0, n_inserts = 0, n_trims = 0, n_ignored = 0;
  bit calm = 0;             // no idling in the last part of the run
  int stall_req = 0;        // long receiver hold-off request, in cycles
  bit in_fire = 0;

  function automatic hact_out_t predict_lookup(hact_in_t w);
    hact_out_t r;
    int slot, best, m, target;
    r = '0;
    if (!rec_on) begin
      r.entries_used = tbl_used[10:0];
      return r;
    end
    slot = -1;
    for (int i = 0; i < Depth; i++)
      if (slot < 0 && tbl_valid[i] && tbl_addr[i] == w.address) slot = i;
    r.accepted = 1'b1;
    if (slot >= 0) begin
      if (tbl_count[slot] != 32'hFFFF_FFFF) tbl_count[slot]++;
      r.exec_count = tbl_count[slot];
    end else begin
      m = (max_reg == 0) ? 1 : (max_reg > Depth ? Depth : int'(max_reg));
      if (tbl_used >= m) begin
        target = (m * 4) / 5;
        while (tbl_used > target) begin
          // lowest count goes first, lower address on a tie
          best = -1;
          for (int i = 0; i < Depth; i++)
            if (tbl_valid[i] && (best < 0 || tbl_count[i] < tbl_count[best] ||
                (tbl_count[i] == tbl_count[best] && tbl_addr[i] < tbl_addr[best])))
              best = i;
          tbl_valid[best] = 1'b0;
          tbl_used--;
          r.evicted++;
        end
      end
      for (int i = 0; i < Depth; i++)
        if (slot < 0 && !tbl_valid[i]) slot = i;
      tbl_valid[slot] = 1'b1;
      tbl_addr[slot]  = w.address;
      tbl_count[slot] = 32'd1;
      tbl_used++;
      r.was_new = 1'b1;
      r.exec_count = 32'd1;
    end
    r.entries_used = tbl_used[10:0];
    return r;
  endfunction

  // accepted words feed the predictor
  always @(posedge clk_i) begin
    in_fire <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) result_q.insert(result_q.size(), predict_lookup(in_data_i));
  end

  // driver: payload changes only at the falling edge
  int send_gap = 0;
  always @(negedge clk_i) begin
    logic nv;
    hact_in_t nd;
    nv = in_valid_i;
    nd = in_data_i;
    if (!in_valid_i || in_fire) begin
      nv = 1'b0;
      if (send_gap > 0) send_gap--;
      else if (word_q.size() > 0) begin
        nd = word_q.pop_front();
        nv = 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 8);
      end
    end
    in_valid_i <= nv;
    in_data_i <= nd;
  end

  // receiver: random stall bursts plus one long hold-off
  int hold = 0;
  always @(negedge clk_i) begin
    if (stall_req > 0 && hold == 0) begin
      hold = stall_req;
      stall_req = 0;
    end
    if (hold > 0) begin
      hold--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      hold = $urandom_range(0, 7);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    hact_out_t want;
    if (out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected result word", 32'd1, 32'd0);
      end else begin
        want = result_q.pop_front();
        if (out_data_o.accepted != want.accepted)
          report_mismatch("accepted", out_data_o.accepted, want.accepted);
        if (out_data_o.was_new != want.was_new)
          report_mismatch("was_new", out_data_o.was_new, want.was_new);
        if (out_data_o.exec_count != want.exec_count)
          report_mismatch("exec_count", out_data_o.exec_count, want.exec_count);
        if (out_data_o.evicted != want.evicted)
          report_mismatch("evicted", out_data_o.evicted, want.evicted);
        if (out_data_o.entries_used != want.entries_used)
          report_mismatch("entries_used", out_data_o.entries_used, want.entries_used);
        if (!want.accepted) n_ignored++;
        else if (want.was_new) n_inserts++;
        else n_hits++;
        if (want.evicted != 0) n_trims++;
      end
    end
  end

  // setup then access cycle; predictor copy follows the write
  task automatic reg_write(logic [2:0] a, logic [31:0] d);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == RegRecordEnable) rec_on = d[0];
    else max_reg = d[10:0];
  endtask

  task automatic drain();
    while (word_q.size() != 0 || in_valid_i || result_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic queue_word(hact_in_t w);
    word_q.insert(word_q.size(), w);
  endtask

  task automatic push_word(logic [23:0] a);
    hact_in_t w;
    w.address = a;
    w.opcode = 8'($urandom_range(0, 255));
    w.operand_len = 2'($urandom_range(0, 3));
    w.operand_bytes = 24'($urandom);
    queue_word(w);
  endtask

  initial begin
    logic [23:0] pool[$];
    int total, n, psize;
    for (int i = 0; i < Depth; i++) begin
      tbl_valid[i] = 1'b0; tbl_addr[i] = '0; tbl_count[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: field extremes, hits, then recording off
    queue_word('{24'h000000, 8'h00, 2'd0, 24'h000000});
    queue_word('{24'hFFFFFF, 8'hFF, 2'd3, 24'hFFFFFF});
    queue_word('{24'h000000, 8'hFF, 2'd1, 24'h0000FF});
    queue_word('{24'hFFFFFF, 8'h00, 2'd2, 24'h00FFFF});
    queue_word('{24'h000000, 8'hA9, 2'd1, 24'h000012});
    for (int i = 0; i < 4; i++) push_word(24'h123400 + 24'(i));
    drain();
    reg_write(RegRecordEnable, 32'd0);
    push_word(24'h000000); push_word(24'h777777);
    drain();
    reg_write(RegRecordEnable, 32'd1);
    // max lowered below occupancy: a hit does not trim, the next miss does
    reg_write(RegMaxEntries, 32'd3);
    push_word(24'hFFFFFF); push_word(24'h00ABCD);
    drain();
    // max of 1 and 0 empty the table on every miss
    reg_write(RegMaxEntries, 32'd1);
    push_word(24'h000011); push_word(24'h000011); push_word(24'h000022);
    drain();
    reg_write(RegMaxEntries, 32'd0);
    push_word(24'h000033); push_word(24'h000044);
    drain();
    // above depth acts as depth
    reg_write(RegMaxEntries, 32'h7FF);
    push_word(24'h000055); push_word(24'h000044);
    drain();

    // random phases: small pools so that hits and trims are frequent
    total = 0;
    for (int ph = 0; total < 1900; ph++) begin
      if (total > 1700) calm = 1;
      case ($urandom_range(0, 9))
        0: reg_write(RegMaxEntries, 32'd1024);
        1: reg_write(RegMaxEntries, 32'd1500);
        2: reg_write(RegMaxEntries, $urandom_range(0, 2));
        default: reg_write(RegMaxEntries, $urandom_range(3, 40));
      endcase
      reg_write(RegRecordEnable, ($urandom_range(0, 7) == 0) ? 32'd0 : 32'd1);
      psize = $urandom_range(2, 50);
      pool.delete();
      pool.insert(pool.size(), 24'h000000);
      pool.insert(pool.size(), 24'hFFFFFF);
      for (int i = 0; i < psize; i++)
        pool.insert(pool.size(), 24'($urandom_range(0, 24'hFFFFFF)));
      n = $urandom_range(40, 120);
      if (ph == 2) stall_req = 6000;   // block fills and stalls its input
      for (int i = 0; i < n; i++)
        if ($urandom_range(0, 3) != 0) push_word(pool[$urandom_range(0, pool.size() - 1)]);
        else push_word(24'($urandom_range(0, 24'hFFFFFF)));
      if (rec_on) total += n;
      drain();
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d inserts, %0d hits, %0d trimming inserts, %0d ignored words",
             n_inserts, n_hits, n_trims, n_ignored);
    $display("under several max_entries settings incl. 0, 1, 1024 and above depth");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
